// ===== hw/rtl/scc_pkg.sv =====
// Package for the stimulation cycle controller.
// Holds the command, state and limits types and the reset constants.
// No dependencies.
`default_nettype none

package scc_pkg;

    // Item kinds carried on the func bit
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SCAN = 1'b1;

    // Configuration register indexes
    localparam logic REG_TIME_FLOOR   = 1'b0;
    localparam logic REG_TIME_CEILING = 1'b1;

    localparam logic [5:0] TIME_FLOOR_RESET   = 6'd4;
    localparam logic [5:0] TIME_CEILING_RESET = 6'd40;
    localparam logic [5:0] PHASE_TIME_RESET   = 6'd4;
    localparam logic [6:0] SECONDS_PER_MINUTE = 7'd60;

    // One command word
    typedef struct packed {
        logic func;
        logic cursor_key_pressed;
        logic pause_key_pressed;
        logic bypass_key_held;
        logic up_key_held;
        logic down_key_held;
    } scc_cmd_t;

    // Controller state; also the source of every result field
    typedef struct packed {
        logic       pause_state;
        logic       cursor_state;
        logic [5:0] contraction_time;
        logic [5:0] relaxation_time;
        logic       bypass_state;
        logic       enable_state;
        logic [1:0] quarter_count;
        logic [6:0] program_count;
        logic [5:0] second_count;
        logic [7:0] minute_count;
    } scc_state_t;

    // Time limits from the configuration registers
    typedef struct packed {
        logic [5:0] time_floor;
        logic [5:0] time_ceiling;
    } scc_limits_t;

    localparam scc_state_t STATE_RESET = '{
        pause_state:      1'b1,
        cursor_state:     1'b0,
        contraction_time: PHASE_TIME_RESET,
        relaxation_time:  PHASE_TIME_RESET,
        bypass_state:     1'b0,
        enable_state:     1'b0,
        quarter_count:    2'd0,
        program_count:    7'd0,
        second_count:     6'd0,
        minute_count:     8'd0
    };

endpackage

`default_nettype wire

// ===== hw/rtl/scc_ifs.sv =====
// Channel interfaces of the stimulation cycle controller:
// command words, status words and configuration writes.
// No dependencies.
`default_nettype none

interface scc_cmd_if;
    logic valid;
    logic ready;
    logic func;
    logic cursor_key_pressed;
    logic pause_key_pressed;
    logic bypass_key_held;
    logic up_key_held;
    logic down_key_held;

    modport source (
        output valid, func, cursor_key_pressed, pause_key_pressed,
               bypass_key_held, up_key_held, down_key_held,
        input  ready
    );
    modport sink (
        input  valid, func, cursor_key_pressed, pause_key_pressed,
               bypass_key_held, up_key_held, down_key_held,
        output ready
    );
endinterface

interface scc_status_if;
    logic       valid;
    logic       ready;
    logic       drive_enable;
    logic       paused_flag;
    logic       editing_relaxation;
    logic       bypass_active;
    logic [5:0] contraction_now;
    logic [5:0] relaxation_now;
    logic [1:0] quarter_now;
    logic [5:0] seconds_now;
    logic [7:0] minutes_now;

    modport source (
        output valid, drive_enable, paused_flag, editing_relaxation, bypass_active,
               contraction_now, relaxation_now, quarter_now, seconds_now, minutes_now,
        input  ready
    );
    modport sink (
        input  valid, drive_enable, paused_flag, editing_relaxation, bypass_active,
               contraction_now, relaxation_now, quarter_now, seconds_now, minutes_now,
        output ready
    );
endinterface

interface scc_cfg_if;
    logic       valid;
    logic       ready;
    logic       reg_index;
    logic [5:0] reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stimulation_cycle_controller.sv =====
// Stimulation cycle controller: command register, next-state logic, status register.
// An accepted word is held in the command register, then its status word in the status register.
// Throughput: one word per cycle while the status channel is not stalled, set by the state update loop.
// Each stage holds while the stage after it is stalled.
// Reset: paused, contraction and relaxation 4, counters zero, floor 4, ceiling 40.
// Depends on scc_pkg, scc_ifs and scc_update.
`default_nettype none

module stimulation_cycle_controller (
    input  wire logic    clk,
    input  wire logic    rst_n,
    scc_cmd_if.sink      cmd,
    scc_status_if.source status,
    scc_cfg_if.sink      cfg
);

    logic                  cmd_valid_reg;
    scc_pkg::scc_cmd_t     cmd_word_reg;
    scc_pkg::scc_cmd_t     cmd_word_next;
    scc_pkg::scc_state_t   state_reg;
    scc_pkg::scc_state_t   state_next;
    scc_pkg::scc_limits_t  limits_reg;
    logic                  out_valid_reg;
    scc_pkg::scc_state_t   out_word_reg;
    logic                  advance;
    logic                  cmd_take;

    // Pipeline flow control
    assign advance   = !out_valid_reg || status.ready;
    assign cmd.ready = !cmd_valid_reg || advance;
    assign cmd_take  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    assign cmd_word_next = '{
        func:               cmd.func,
        cursor_key_pressed: cmd.cursor_key_pressed,
        pause_key_pressed:  cmd.pause_key_pressed,
        bypass_key_held:    cmd.bypass_key_held,
        up_key_held:        cmd.up_key_held,
        down_key_held:      cmd.down_key_held
    };

    // Command register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            cmd_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_word_reg <= cmd_word_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.time_floor   <= scc_pkg::TIME_FLOOR_RESET;
            limits_reg.time_ceiling <= scc_pkg::TIME_CEILING_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.reg_index)
                scc_pkg::REG_TIME_FLOOR:   limits_reg.time_floor   <= cfg.reg_data;
                scc_pkg::REG_TIME_CEILING: limits_reg.time_ceiling <= cfg.reg_data;
                default:                   limits_reg              <= limits_reg;
            endcase
        end
    end

    scc_update u_update (
        .state_cur (state_reg),
        .cmd_word  (cmd_word_reg),
        .limits    (limits_reg),
        .state_new (state_next)
    );

    // Controller state and status valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scc_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= cmd_valid_reg;
            if (cmd_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Status word register
    always_ff @(posedge clk)
    begin
        if (advance && cmd_valid_reg)
        begin
            out_word_reg <= state_next;
        end
    end

    assign status.valid              = out_valid_reg;
    assign status.drive_enable       = out_word_reg.enable_state;
    assign status.paused_flag        = out_word_reg.pause_state;
    assign status.editing_relaxation = out_word_reg.cursor_state;
    assign status.bypass_active      = out_word_reg.bypass_state;
    assign status.contraction_now    = out_word_reg.contraction_time;
    assign status.relaxation_now     = out_word_reg.relaxation_time;
    assign status.quarter_now        = out_word_reg.quarter_count;
    assign status.seconds_now        = out_word_reg.second_count;
    assign status.minutes_now        = out_word_reg.minute_count;

    // Seconds never reach a full minute
    a_seconds_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, state_reg.second_count} < scc_pkg::SECONDS_PER_MINUTE)
        else $error("second count out of range");

    // A paused tick holds the counters and turns the drive off
    a_paused_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_valid_reg && (cmd_word_reg.func == scc_pkg::FUNC_TICK)
         && state_reg.pause_state)
        |=> ($stable(state_reg.quarter_count) && $stable(state_reg.program_count)
             && !state_reg.enable_state))
        else $error("paused tick moved the counters");

    // Holding bypass during a scan forces the drive on
    a_bypass_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_valid_reg && (cmd_word_reg.func == scc_pkg::FUNC_SCAN)
         && cmd_word_reg.bypass_key_held)
        |=> (state_reg.bypass_state && state_reg.enable_state && out_valid_reg))
        else $error("bypass did not force the drive");

    // A new status word only follows a registered command
    a_status_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg ##1 out_valid_reg) |-> $past(cmd_valid_reg))
        else $error("status word without a command");

endmodule

`default_nettype wire

// ===== hw/rtl/scc_time_step.sv =====
// Steps one phase time up and/or down within the floor and ceiling.
// Depends on nothing outside this file.
`default_nettype none

module scc_time_step (
    input  wire logic [5:0] time_cur,
    input  wire logic       up,
    input  wire logic       down,
    input  wire logic [5:0] time_floor,
    input  wire logic [5:0] time_ceiling,
    output logic      [5:0] time_new
);

    logic [5:0] after_up;

    // Increment first, then decrement checked against the incremented value
    always_comb
    begin
        after_up = time_cur;
        if (up && (time_cur < time_ceiling))
        begin
            after_up = time_cur + 6'd1;
        end
        time_new = after_up;
        if (down && (after_up > time_floor))
        begin
            time_new = after_up - 6'd1;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/scc_update.sv =====
// Next-state logic of the controller for one command word.
// Depends on scc_pkg and scc_time_step.
`default_nettype none

module scc_update (
    input  wire scc_pkg::scc_state_t  state_cur,
    input  wire scc_pkg::scc_cmd_t    cmd_word,
    input  wire scc_pkg::scc_limits_t limits,
    output scc_pkg::scc_state_t       state_new
);

    logic       cursor_after;
    logic [5:0] selected_time;
    logic [5:0] stepped_time;
    logic [1:0] quarter_inc;
    logic [6:0] second_inc;
    logic [6:0] program_inc;
    logic [6:0] cycle_total;

    // Scan side: cursor toggles first, then the selected time is stepped
    assign cursor_after  = state_cur.cursor_state ^ cmd_word.cursor_key_pressed;
    assign selected_time = cursor_after ? state_cur.relaxation_time
                                        : state_cur.contraction_time;

    scc_time_step u_time_step (
        .time_cur     (selected_time),
        .up           (cmd_word.up_key_held),
        .down         (cmd_word.down_key_held),
        .time_floor   (limits.time_floor),
        .time_ceiling (limits.time_ceiling),
        .time_new     (stepped_time)
    );

    // Tick side counters
    assign quarter_inc = state_cur.quarter_count + 2'd1;
    assign second_inc  = {1'b0, state_cur.second_count} + 7'd1;
    assign program_inc = state_cur.program_count + 7'd1;
    assign cycle_total = {1'b0, state_cur.contraction_time}
                       + {1'b0, state_cur.relaxation_time};

    always_comb
    begin
        state_new = state_cur;
        if (cmd_word.func == scc_pkg::FUNC_SCAN)
        begin
            state_new.cursor_state = cursor_after;
            state_new.pause_state  = state_cur.pause_state ^ cmd_word.pause_key_pressed;
            if (cmd_word.bypass_key_held)
            begin
                state_new.bypass_state = 1'b1;
                state_new.enable_state = 1'b1;
            end
            else if (state_cur.bypass_state)
            begin
                state_new.bypass_state = 1'b0;
                state_new.enable_state = 1'b0;
            end
            if (cursor_after)
            begin
                state_new.relaxation_time = stepped_time;
            end
            else
            begin
                state_new.contraction_time = stepped_time;
            end
        end
        else if (state_cur.pause_state)
        begin
            // Paused tick: drive off, counters hold
            state_new.enable_state = 1'b0;
        end
        else
        begin
            state_new.quarter_count = quarter_inc;
            if (quarter_inc == 2'd0)
            begin
                if (second_inc >= scc_pkg::SECONDS_PER_MINUTE)
                begin
                    state_new.second_count = 6'd0;
                    state_new.minute_count = state_cur.minute_count + 8'd1;
                end
                else
                begin
                    state_new.second_count = second_inc[5:0];
                end
            end
            state_new.enable_state = (program_inc <= {1'b0, state_cur.contraction_time});
            state_new.program_count = (program_inc > cycle_total) ? 7'd0 : program_inc;
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_stimulation_cycle_controller.sv =====
// Testbench for the stimulation cycle controller: drives command words and register
// writes, predicts every status word and checks each one field by field.
// Depends on scc_pkg, scc_ifs and the stimulation_cycle_controller RTL.
module tb_stimulation_cycle_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TIMEOUT_CYCLES     = 500_000;
    localparam int unsigned RANDOM_PHASES      = 6;
    localparam int unsigned RANDOM_PHASE_WORDS = 250;
    localparam int unsigned REPORT_LIMIT       = 10;

    // Layout of one status word, in port order
    typedef struct packed {
        logic       drive_enable;
        logic       paused_flag;
        logic       editing_relaxation;
        logic       bypass_active;
        logic [5:0] contraction_now;
        logic [5:0] relaxation_now;
        logic [1:0] quarter_now;
        logic [5:0] seconds_now;
        logic [7:0] minutes_now;
    } status_word_t;

    logic clk = 1'b0;
    logic rst_n;

    scc_cmd_if    cmd_ch();
    scc_status_if status_ch();
    scc_cfg_if    cfg_ch();

    stimulation_cycle_controller u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .status (status_ch),
        .cfg    (cfg_ch)
    );

    // Predicted controller state and limits
    scc_pkg::scc_state_t   ctl_state;
    scc_pkg::scc_limits_t  ctl_limits;
    status_word_t          pending_status[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned holdoff_left   = 0;
    logic        bypass_hold    = 1'b0;

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Step one phase time up and/or down inside the current limits
    function automatic logic [5:0] step_phase_time(logic [5:0] t, logic up, logic down);
        logic [5:0] v;
        v = t;
        if (up && v < ctl_limits.time_ceiling)
            v = v + 6'd1;
        if (down && v > ctl_limits.time_floor)
            v = v - 6'd1;
        return v;
    endfunction

    // Apply one command word to the predicted state, return the status it produces
    function automatic status_word_t advance_controller(scc_pkg::scc_cmd_t c);
        status_word_t w;
        logic [6:0]   cycle_len;
        if (c.func == scc_pkg::FUNC_SCAN)
        begin
            if (c.cursor_key_pressed)
                ctl_state.cursor_state = ~ctl_state.cursor_state;
            if (c.pause_key_pressed)
                ctl_state.pause_state = ~ctl_state.pause_state;
            if (c.bypass_key_held)
            begin
                ctl_state.bypass_state = 1'b1;
                ctl_state.enable_state = 1'b1;
            end
            else if (ctl_state.bypass_state)
            begin
                ctl_state.bypass_state = 1'b0;
                ctl_state.enable_state = 1'b0;
            end
            if (!ctl_state.cursor_state)
                ctl_state.contraction_time = step_phase_time(ctl_state.contraction_time,
                                                             c.up_key_held, c.down_key_held);
            else
                ctl_state.relaxation_time = step_phase_time(ctl_state.relaxation_time,
                                                            c.up_key_held, c.down_key_held);
        end
        else if (ctl_state.pause_state)
        begin
            // paused tick: drive off, counters hold
            ctl_state.enable_state = 1'b0;
        end
        else
        begin
            ctl_state.quarter_count = ctl_state.quarter_count + 2'd1;
            if (ctl_state.quarter_count == 2'd0)
            begin
                ctl_state.second_count = ctl_state.second_count + 6'd1;
                if ({1'b0, ctl_state.second_count} >= scc_pkg::SECONDS_PER_MINUTE)
                begin
                    ctl_state.second_count = 6'd0;
                    ctl_state.minute_count = ctl_state.minute_count + 8'd1;
                end
            end
            ctl_state.program_count = ctl_state.program_count + 7'd1;
            ctl_state.enable_state  = (ctl_state.program_count <= {1'b0, ctl_state.contraction_time});
            cycle_len = {1'b0, ctl_state.contraction_time} + {1'b0, ctl_state.relaxation_time};
            if (ctl_state.program_count > cycle_len)
                ctl_state.program_count = 7'd0;
        end
        w.drive_enable       = ctl_state.enable_state;
        w.paused_flag        = ctl_state.pause_state;
        w.editing_relaxation = ctl_state.cursor_state;
        w.bypass_active      = ctl_state.bypass_state;
        w.contraction_now    = ctl_state.contraction_time;
        w.relaxation_now     = ctl_state.relaxation_time;
        w.quarter_now        = ctl_state.quarter_count;
        w.seconds_now        = ctl_state.second_count;
        w.minutes_now        = ctl_state.minute_count;
        return w;
    endfunction

    function automatic scc_pkg::scc_cmd_t make_cmd(logic func, int unsigned cursor,
                                                   int unsigned pause, int unsigned bypass,
                                                   int unsigned up, int unsigned down);
        scc_pkg::scc_cmd_t c;
        c.func               = func;
        c.cursor_key_pressed = (cursor != 0);
        c.pause_key_pressed  = (pause != 0);
        c.bypass_key_held    = (bypass != 0);
        c.up_key_held        = (up != 0);
        c.down_key_held      = (down != 0);
        return c;
    endfunction

    // Mostly plausible keypad activity; pause is left quickly so ticks do real work
    function automatic scc_pkg::scc_cmd_t random_cmd();
        scc_pkg::scc_cmd_t c;
        int unsigned       pause_pct;
        c = scc_pkg::scc_cmd_t'(6'($urandom_range(63)));
        if ($urandom_range(99) < 5)
            return c;
        if ($urandom_range(99) < 50)
        begin
            c.func = scc_pkg::FUNC_TICK;
            return c;
        end
        if ($urandom_range(99) < 15)
            bypass_hold = ~bypass_hold;
        pause_pct = ctl_state.pause_state ? 40 : 3;
        c.func               = scc_pkg::FUNC_SCAN;
        c.cursor_key_pressed = ($urandom_range(99) < 12);
        c.pause_key_pressed  = ($urandom_range(99) < pause_pct);
        c.bypass_key_held    = bypass_hold;
        c.up_key_held        = ($urandom_range(99) < 35);
        c.down_key_held      = ($urandom_range(99) < 35);
        return c;
    endfunction

    // Offer one command word, with random idle cycles ahead of it
    task automatic send_word(scc_pkg::scc_cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid              <= 1'b1;
        cmd_ch.func               <= c.func;
        cmd_ch.cursor_key_pressed <= c.cursor_key_pressed;
        cmd_ch.pause_key_pressed  <= c.pause_key_pressed;
        cmd_ch.bypass_key_held    <= c.bypass_key_held;
        cmd_ch.up_key_held        <= c.up_key_held;
        cmd_ch.down_key_held      <= c.down_key_held;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        pending_status.push_back(advance_controller(c));
    endtask

    // Stop offering words and wait for every predicted status word
    task automatic wait_for_drain();
        cmd_ch.valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [5:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.reg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        if (idx == scc_pkg::REG_TIME_FLOOR)
            ctl_limits.time_floor = data;
        else
            ctl_limits.time_ceiling = data;
        @(posedge clk);
    endtask

    task automatic set_limits(logic [5:0] floor_v, logic [5:0] ceiling_v);
        wait_for_drain();
        write_reg(scc_pkg::REG_TIME_FLOOR, floor_v);
        write_reg(scc_pkg::REG_TIME_CEILING, ceiling_v);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("status mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Receiver: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (holdoff_left != 0)
        begin
            status_ch.ready <= 1'b0;
            holdoff_left = holdoff_left - 1;
        end
        else
            status_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Status word checker
    always @(posedge clk)
    begin
        status_word_t got;
        status_word_t want;
        if (rst_n === 1'b1 && status_ch.valid === 1'b1 && status_ch.ready === 1'b1)
        begin
            got = {status_ch.drive_enable, status_ch.paused_flag,
                   status_ch.editing_relaxation, status_ch.bypass_active,
                   status_ch.contraction_now, status_ch.relaxation_now,
                   status_ch.quarter_now, status_ch.seconds_now, status_ch.minutes_now};
            if (pending_status.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("status word %h arrived with none predicted", got);
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("drive_enable", want.drive_enable, got.drive_enable);
                check_field("paused_flag", want.paused_flag, got.paused_flag);
                check_field("editing_relaxation", want.editing_relaxation,
                            got.editing_relaxation);
                check_field("bypass_active", want.bypass_active, got.bypass_active);
                check_field("contraction_now", want.contraction_now, got.contraction_now);
                check_field("relaxation_now", want.relaxation_now, got.relaxation_now);
                check_field("quarter_now", want.quarter_now, got.quarter_now);
                check_field("seconds_now", want.seconds_now, got.seconds_now);
                check_field("minutes_now", want.minutes_now, got.minutes_now);
            end
        end
    end

    // Hand-picked words from reset: paused tick, bypass, key combinations, cycle restart
    task automatic test_directed();
        send_idle_pct  = 21;
        recv_stall_pct = 54;
        send_word(make_cmd(scc_pkg::FUNC_TICK, 1, 1, 1, 1, 1));   // keys ignored, paused
        send_word(make_cmd(scc_pkg::FUNC_SCAN, 0, 0, 0, 0, 0));
        send_word(make_cmd(scc_pkg::FUNC_SCAN, 0, 1, 0, 0, 0));   // unpause
        repeat (3) send_word(make_cmd(scc_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
        send_word(make_cmd(scc_pkg::FUNC_SCAN, 0, 0, 1, 0, 0));   // bypass on
        send_word(make_cmd(scc_pkg::FUNC_TICK, 0, 0, 0, 0, 0));   // program overrides bypass
        send_word(make_cmd(scc_pkg::FUNC_SCAN, 0, 0, 0, 0, 0));   // bypass released
        send_word(make_cmd(scc_pkg::FUNC_SCAN, 0, 0, 0, 1, 0));
        send_word(make_cmd(scc_pkg::FUNC_SCAN, 0, 0, 0, 1, 1));   // up then down
        repeat (2) send_word(make_cmd(scc_pkg::FUNC_SCAN, 0, 0, 0, 0, 1));   // stops at floor
        send_word(make_cmd(scc_pkg::FUNC_SCAN, 1, 0, 0, 1, 0));   // edit relaxation
        send_word(make_cmd(scc_pkg::FUNC_SCAN, 1, 1, 1, 1, 1));   // every key at once
        send_word(make_cmd(scc_pkg::FUNC_TICK, 0, 0, 0, 0, 0));   // paused while bypassed
        send_word(make_cmd(scc_pkg::FUNC_SCAN, 0, 1, 0, 0, 0));
        repeat (6) send_word(make_cmd(scc_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
        wait_for_drain();
    endtask

    // Long cycle, then shrink both times under the program counter
    task automatic test_cycle_shrink();
        set_limits(6'd1, 6'd63);
        if (ctl_state.pause_state)
            send_word(make_cmd(scc_pkg::FUNC_SCAN, 0, 1, 0, 0, 0));
        if (ctl_state.cursor_state)
            send_word(make_cmd(scc_pkg::FUNC_SCAN, 1, 0, 0, 0, 0));
        repeat (20) send_word(make_cmd(scc_pkg::FUNC_SCAN, 0, 0, 0, 1, 0));
        repeat (30) send_word(make_cmd(scc_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
        repeat (63) send_word(make_cmd(scc_pkg::FUNC_SCAN, 0, 0, 0, 0, 1));
        send_word(make_cmd(scc_pkg::FUNC_SCAN, 1, 0, 0, 0, 0));
        repeat (63) send_word(make_cmd(scc_pkg::FUNC_SCAN, 0, 0, 0, 0, 1));
        send_word(make_cmd(scc_pkg::FUNC_SCAN, 1, 0, 0, 0, 0));
        repeat (4) send_word(make_cmd(scc_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
        wait_for_drain();
    endtask

    // Receiver holds off so the block fills; later the sender waits for a full drain
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_left   = 60;
        repeat (30) send_word(random_cmd());
        wait_for_drain();
        recv_stall_pct = 54;
        repeat (20) send_word(random_cmd());
        wait_for_drain();
    endtask

    // Tick until the seconds counter rolls over into the next minute
    task automatic test_minute_rollover();
        logic [7:0] start_minute;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        if (ctl_state.pause_state)
            send_word(make_cmd(scc_pkg::FUNC_SCAN, 0, 1, 0, 0, 0));
        start_minute = ctl_state.minute_count;
        while (ctl_state.minute_count == start_minute)
            send_word(make_cmd(scc_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
        wait_for_drain();
    endtask

    // Random words under several limit settings and idling patterns
    task automatic test_random_phases();
        logic [5:0] floor_v;
        logic [5:0] ceiling_v;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    floor_v   = scc_pkg::TIME_FLOOR_RESET;
                    ceiling_v = scc_pkg::TIME_CEILING_RESET;
                end
                1: begin floor_v = 6'd1;  ceiling_v = 6'd63; end
                2: begin floor_v = 6'd63; ceiling_v = 6'd63; end
                3: begin floor_v = 6'd1;  ceiling_v = 6'd1;  end
                4: begin floor_v = 6'd50; ceiling_v = 6'd10; end   // floor above ceiling
                default:
                begin
                    floor_v   = 6'($urandom_range(63, 1));
                    ceiling_v = 6'($urandom_range(63, 1));
                end
            endcase
            set_limits(floor_v, ceiling_v);
            if (p < 2)
            begin
                send_idle_pct  = 21;
                recv_stall_pct = 54;
            end
            else if (p < 4)
            begin
                send_idle_pct  = 54;
                recv_stall_pct = 21;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            repeat (RANDOM_PHASE_WORDS) send_word(random_cmd());
        end
        wait_for_drain();
    endtask

    initial
    begin
        rst_n                     = 1'b0;
        cmd_ch.valid              = 1'b0;
        cmd_ch.func               = scc_pkg::FUNC_TICK;
        cmd_ch.cursor_key_pressed = 1'b0;
        cmd_ch.pause_key_pressed  = 1'b0;
        cmd_ch.bypass_key_held    = 1'b0;
        cmd_ch.up_key_held        = 1'b0;
        cmd_ch.down_key_held      = 1'b0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.reg_index          = scc_pkg::REG_TIME_FLOOR;
        cfg_ch.reg_data           = 6'd0;
        status_ch.ready           = 1'b0;
        ctl_state                 = scc_pkg::STATE_RESET;
        ctl_limits.time_floor     = scc_pkg::TIME_FLOOR_RESET;
        ctl_limits.time_ceiling   = scc_pkg::TIME_CEILING_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_cycle_shrink();
        test_backpressure();
        test_minute_rollover();
        test_random_phases();

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
